### design/obm_pkg.sv
// ----------------------------------------------------------------------------
// obm_pkg
// Types and constants shared by the 1-Wire bus master core.
// ----------------------------------------------------------------------------
package obm_pkg;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_RESET = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   localparam int         CSR_COUNT      = 8;
   localparam int         CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESET_LOW_TIME   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESENCE_WAIT    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESET_RECOVERY   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_ONE_LOW    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_ZERO_LOW   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_LOW         = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_SAMPLE_TIME = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOT_LENGTH      = 3'd7;

   localparam logic [15:0] CSR_RESET_VALUE [CSR_COUNT] = '{
      16'd480, 16'd70, 16'd410, 16'd6, 16'd60, 16'd6, 16'd15, 16'd70
   };

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
      logic       bus_sample;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       done_res;
      logic       presence;
      logic [7:0] read_data;
      logic       status;
   } rsp_type;

   typedef struct packed {
      logic       tick;
      logic [1:0] op;
      logic [7:0] data;
      logic       smp;
   } cmd_type;

endpackage

### design/obm_fifo.sv
// ----------------------------------------------------------------------------
// obm_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module obm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    data_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full     = (cnt_ff == CNT_BITS'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/obm_front.sv
// ----------------------------------------------------------------------------
// obm_front
// Accepts request items, tags ticks apart from commands and queues them.
// ----------------------------------------------------------------------------
module obm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  obm_pkg::req_type req_data,
   output logic             req_full,
   output obm_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_take
);
   import obm_pkg::*;

   cmd_type cmd_in;
   logic    cmd_empty;

   always_comb begin
      cmd_in.tick = (req_data.func == FUNC_TICK);
      cmd_in.op   = req_data.func;
      cmd_in.data = (req_data.func == FUNC_WRITE) ? req_data.data_byte : 8'd0;
      cmd_in.smp  = req_data.bus_sample;
   end

   obm_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(2)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(cmd_in),
      .full     (req_full),
      .pop      (cmd_take),
      .pop_data (cmd),
      .empty    (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

### design/obm_back.sv
// ----------------------------------------------------------------------------
// obm_back
// Bus timing engine: runs reset and byte slots, queues one result per item.
// ----------------------------------------------------------------------------
module obm_back #(
   parameter int TIME_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  obm_pkg::cmd_type                      cmd,
   input  logic                                  cmd_valid,
   output logic                                  cmd_take,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [obm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [TIME_BITS-1:0]                  csr_wdata,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output obm_pkg::rsp_type                      rsp_data
);
   import obm_pkg::*;

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_RST_LOW  = 3'd1;
   localparam logic [2:0] PH_RST_WAIT = 3'd2;
   localparam logic [2:0] PH_RST_REC  = 3'd3;
   localparam logic [2:0] PH_SLOT     = 3'd4;

   logic [TIME_BITS-1:0] cfg_ff [CSR_COUNT];
   logic [2:0]           phase_ff, phase_in;
   logic [1:0]           op_ff, op_in;
   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic [2:0]           bit_ff, bit_in;
   logic [7:0]           shift_ff, shift_in;
   logic                 pres_ff, pres_in;
   logic [7:0]           rdata_ff, rdata_in;
   logic                 rsp_full;
   logic                 fire;
   rsp_type              rsp_in;

   function automatic logic [TIME_BITS-1:0] eff(input logic [TIME_BITS-1:0] v);
      return (v == '0) ? TIME_BITS'(1) : v;
   endfunction

   assign csr_ready = 1'b1;
   assign fire      = cmd_valid && !rsp_full;
   assign cmd_take  = fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            cfg_ff[i] <= TIME_BITS'(CSR_RESET_VALUE[i]);
         end
      end else if (csr_valid && csr_ready) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      logic [TIME_BITS-1:0] tick_inc;
      logic [TIME_BITS-1:0] slen;
      logic [TIME_BITS-1:0] sat;
      logic [TIME_BITS-1:0] low_time;
      logic [7:0]           shift_tmp;
      logic                 is_read;

      phase_in  = phase_ff;
      op_in     = op_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      pres_in   = pres_ff;
      rdata_in  = rdata_ff;
      rsp_in    = '0;
      tick_inc  = tick_ff + 1'b1;
      slen      = eff(cfg_ff[CSR_SLOT_LENGTH]);
      sat       = eff(cfg_ff[CSR_READ_SAMPLE_TIME]);
      is_read   = (op_ff == FUNC_READ);
      shift_tmp = shift_ff;
      if (sat > slen) begin
         sat = slen;
      end

      if (!cmd.tick) begin
         if (phase_ff != PH_IDLE) begin
            rsp_in.status = 1'b1;
         end else begin
            op_in   = cmd.op;
            tick_in = '0;
            bit_in  = '0;
            if (cmd.op == FUNC_RESET) begin
               phase_in = PH_RST_LOW;
            end else begin
               phase_in = PH_SLOT;
               shift_in = cmd.data;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_RST_LOW: begin
               tick_in = tick_inc;
               if (tick_inc >= eff(cfg_ff[CSR_RESET_LOW_TIME])) begin
                  phase_in = PH_RST_WAIT;
                  tick_in  = '0;
               end
            end
            PH_RST_WAIT: begin
               tick_in = tick_inc;
               if (tick_inc >= eff(cfg_ff[CSR_PRESENCE_WAIT])) begin
                  pres_in  = !cmd.smp;
                  phase_in = PH_RST_REC;
                  tick_in  = '0;
               end
            end
            PH_RST_REC: begin
               tick_in = tick_inc;
               if (tick_inc >= eff(cfg_ff[CSR_RESET_RECOVERY])) begin
                  phase_in        = PH_IDLE;
                  rsp_in.done_res = 1'b1;
               end
            end
            PH_SLOT: begin
               tick_in = tick_inc;
               if (is_read && tick_inc == sat) begin
                  shift_tmp = {cmd.smp, shift_ff[7:1]};
               end
               if (tick_inc >= slen) begin
                  if (!is_read) begin
                     shift_tmp = {1'b0, shift_tmp[7:1]};
                  end
                  tick_in = '0;
                  if (bit_ff == 3'd7) begin
                     if (is_read) begin
                        rdata_in = shift_tmp;
                     end
                     phase_in        = PH_IDLE;
                     bit_in          = '0;
                     rsp_in.done_res = 1'b1;
                  end else begin
                     bit_in = bit_ff + 1'b1;
                  end
               end
               shift_in = shift_tmp;
            end
            default: begin
            end
         endcase
      end

      if (op_in == FUNC_READ) begin
         low_time = eff(cfg_ff[CSR_READ_LOW]);
      end else if (shift_in[0]) begin
         low_time = eff(cfg_ff[CSR_WRITE_ONE_LOW]);
      end else begin
         low_time = eff(cfg_ff[CSR_WRITE_ZERO_LOW]);
      end

      rsp_in.drive_low = (phase_in == PH_RST_LOW) ||
                         (phase_in == PH_SLOT && tick_in < low_time && tick_in < slen);
      rsp_in.presence  = pres_in;
      rsp_in.read_data = rdata_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= '0;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         pres_ff  <= 1'b0;
         rdata_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
         rdata_ff <= rdata_in;
      end
   end

   obm_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(2)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fire),
      .push_data(rsp_in),
      .full     (rsp_full),
      .pop      (rsp_pop),
      .pop_data (rsp_data),
      .empty    (rsp_empty)
   );

`ifndef SYNTHESIS
   a_bit_only_in_slot: assert property (@(posedge clock) disable iff (reset)
      (bit_ff != 3'd0) |-> (phase_ff == PH_SLOT))
      else $error("bit index set outside a byte slot");

   a_reject_only_busy: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_in.status) |-> (phase_ff != PH_IDLE))
      else $error("command rejected while idle");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_in.done_res) |=> (phase_ff == PH_IDLE))
      else $error("command finished but engine not idle");

   a_reset_low_drives: assert property (@(posedge clock) disable iff (reset)
      (fire && phase_in == PH_RST_LOW) |-> rsp_in.drive_low)
      else $error("line released during reset pulse");
`endif

endmodule

### design/onewire_bus_master_core.sv
// ----------------------------------------------------------------------------
// onewire_bus_master_core
// 1-Wire bus master driven by one-microsecond tick items.
// ----------------------------------------------------------------------------
// Each request is a tick or a command (bus reset, write byte, read byte) and
// yields exactly one response carrying the line drive for the coming tick,
// done, presence, the last read byte and a busy-reject status. The core takes
// one request per clock while the response queue has room; a request waits
// in the command queue and its response is pushed into the response queue
// when the timing engine takes it, a rate set by the engine updating the
// whole bus state once per item. Two-entry command and response queues let
// either side stall on its own. The user must write timing registers through
// the csr port only while idle; the core does not enforce it. Zero acts as one.
// ----------------------------------------------------------------------------
module onewire_bus_master_core #(
   parameter int TIME_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   input  obm_pkg::req_type                   req_data,
   output logic                               req_full,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output obm_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [obm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [TIME_BITS-1:0]               csr_wdata
);
   import obm_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_take;

   obm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd      (cmd),
      .cmd_valid(cmd_valid),
      .cmd_take (cmd_take)
   );

   obm_back #(
      .TIME_BITS(TIME_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cmd_valid(cmd_valid),
      .cmd_take (cmd_take),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule
